// ----- rtl/nsc_pkg.sv -----
// ----------------------------------------------------------------------------
// nsc_pkg: shared types and constants for the number string classifier
// Holds the class codes, the scanner phase codes and the character constants.
// ----------------------------------------------------------------------------
package nsc_pkg;

    // Result class of one string.
    typedef enum logic [1:0] {
        CLS_NOT  = 2'd0,
        CLS_INT  = 2'd1,
        CLS_REAL = 2'd2,
        CLS_EXP  = 2'd3
    } class_t;

    // Scanner phase; codes ten to fifteen carry no meaning and reject.
    typedef enum logic [3:0] {
        PH_LEAD      = 4'd0,
        PH_SIGN      = 4'd1,
        PH_INT       = 4'd2,
        PH_FRAC      = 4'd3,
        PH_FRAC_SP   = 4'd4,
        PH_EXP_MARK  = 4'd5,
        PH_EXP_SIGN  = 4'd6,
        PH_EXP_DIG   = 4'd7,
        PH_TRAIL_INT = 4'd8,
        PH_TRAIL_EXP = 4'd9
    } phase_t;

    // Character constants.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_LOWER_E = 8'h65;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

endpackage

// ----- rtl/number_string_classifier.sv -----
// ----------------------------------------------------------------------------
// number_string_classifier: decimal number literal recognizer
// Scans a string one byte per beat and reports its class at the string end.
// ----------------------------------------------------------------------------
// An end beat passes the input register, then the result register.
// Throughput: one byte beat per cycle unless an end beat stalls; the input and
// result registers let non-end bytes follow while a result waits.
// Input stall rises only when an end beat waits behind a stalled result.
// Reset: rst_n clears all control state and the scanner to leading space.
module number_string_classifier
    import nsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] ch,
    input  logic       end_of_string,
    input  logic       byte_valid,
    output logic       byte_stall,
    output logic [1:0] class_code,
    output logic       is_integer,
    output logic       result_valid,
    input  logic       result_stall
);

    // Input register.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] ch_reg;
    logic       eos_reg;

    // Scanner state.
    phase_t phase_reg, phase_next;
    logic   before_reg, before_next;
    logic   after_reg, after_next;
    logic   zeros_reg, zeros_next;
    logic   rejected_reg, rejected_next;

    // Result register.
    logic   out_valid_reg, out_valid_next;
    class_t class_reg;
    class_t class_now;

    logic accept;
    logic is_end;
    logic blocked;
    logic advance;
    logic sp, dg, ex, sg, pt;

    // Byte decode of the registered beat.
    assign sp = (ch_reg == CH_SPACE) || (ch_reg >= CH_TAB && ch_reg <= CH_CR);
    assign dg = (ch_reg >= CH_ZERO) && (ch_reg <= CH_NINE);
    assign ex = (ch_reg == CH_UPPER_E) || (ch_reg == CH_LOWER_E);
    assign sg = (ch_reg == CH_PLUS) || (ch_reg == CH_MINUS);
    assign pt = (ch_reg == CH_POINT);
    assign is_end = eos_reg || (ch_reg == CH_NUL);

    // Handshake: an end beat waits only when the result register is held.
    assign blocked    = in_valid_reg && is_end && out_valid_reg && result_stall;
    assign advance    = in_valid_reg && !blocked;
    assign byte_stall = blocked;
    assign accept     = byte_valid && !byte_stall;

    assign in_valid_next = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    // Class of the string as it stands.
    always_comb
    begin
        class_now = CLS_NOT;
        if (!rejected_reg)
        begin
            case (phase_reg)
                PH_INT, PH_TRAIL_INT: class_now = CLS_INT;
                PH_FRAC, PH_FRAC_SP:
                begin
                    if (zeros_reg)
                        class_now = CLS_INT;
                    else if (before_reg || after_reg)
                        class_now = CLS_REAL;
                    else
                        class_now = CLS_NOT;
                end
                PH_EXP_DIG, PH_TRAIL_EXP: class_now = CLS_EXP;
                default: class_now = CLS_NOT;
            endcase
        end
    end

    // Next scanner state.
    always_comb
    begin
        phase_next    = phase_reg;
        before_next   = before_reg;
        after_next    = after_reg;
        zeros_next    = zeros_reg;
        rejected_next = rejected_reg;
        if (advance && is_end)
        begin
            phase_next    = PH_LEAD;
            before_next   = 1'b0;
            after_next    = 1'b0;
            zeros_next    = 1'b0;
            rejected_next = 1'b0;
        end
        else if (advance && !rejected_reg)
        begin
            case (phase_reg)
                PH_LEAD, PH_SIGN:
                begin
                    if (sp && phase_reg == PH_LEAD)
                        phase_next = PH_LEAD;
                    else if (sg && phase_reg == PH_LEAD)
                        phase_next = PH_SIGN;
                    else if (dg)
                    begin
                        before_next = 1'b1;
                        phase_next  = PH_INT;
                    end
                    else if (pt)
                    begin
                        zeros_next = 1'b1;
                        phase_next = PH_FRAC;
                    end
                    else
                        rejected_next = 1'b1;
                end
                PH_INT:
                begin
                    if (dg)
                        phase_next = PH_INT;
                    else if (pt)
                    begin
                        zeros_next = 1'b1;
                        phase_next = PH_FRAC;
                    end
                    else if (ex)
                        phase_next = PH_EXP_MARK;
                    else if (sp)
                        phase_next = PH_TRAIL_INT;
                    else
                        rejected_next = 1'b1;
                end
                PH_FRAC:
                begin
                    if (dg)
                    begin
                        after_next = 1'b1;
                        if (ch_reg != CH_ZERO)
                            zeros_next = 1'b0;
                    end
                    else if (sp)
                        phase_next = PH_FRAC_SP;
                    else if (ex)
                    begin
                        zeros_next = 1'b0;
                        if (before_reg || after_reg)
                            phase_next = PH_EXP_MARK;
                        else
                            rejected_next = 1'b1;
                    end
                    else
                        rejected_next = 1'b1;
                end
                PH_FRAC_SP, PH_TRAIL_INT, PH_TRAIL_EXP:
                begin
                    if (!sp)
                        rejected_next = 1'b1;
                end
                PH_EXP_MARK:
                begin
                    if (sg)
                        phase_next = PH_EXP_SIGN;
                    else if (dg)
                        phase_next = PH_EXP_DIG;
                    else
                        rejected_next = 1'b1;
                end
                PH_EXP_SIGN:
                begin
                    if (dg)
                        phase_next = PH_EXP_DIG;
                    else
                        rejected_next = 1'b1;
                end
                PH_EXP_DIG:
                begin
                    if (dg)
                        phase_next = PH_EXP_DIG;
                    else if (sp)
                        phase_next = PH_TRAIL_EXP;
                    else
                        rejected_next = 1'b1;
                end
                default: rejected_next = 1'b1;
            endcase
        end
    end

    // Result register valid: loads on an end beat, clears when taken.
    always_comb
    begin
        if (advance && is_end)
            out_valid_next = 1'b1;
        else if (result_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_LEAD;
            before_reg    <= 1'b0;
            after_reg     <= 1'b0;
            zeros_reg     <= 1'b0;
            rejected_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            before_reg    <= before_next;
            after_reg     <= after_next;
            zeros_reg     <= zeros_next;
            rejected_reg  <= rejected_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg  <= ch;
            eos_reg <= end_of_string;
        end
        if (advance && is_end)
            class_reg <= class_now;
    end

    assign result_valid = out_valid_reg;
    assign class_code   = class_reg;
    assign is_integer   = (class_reg == CLS_INT);

endmodule

// ----- rtl/nsc_checker.sv -----
// ----------------------------------------------------------------------------
// nsc_checker: port checks for the number string classifier
// Watches the top-level ports and reports protocol and result slips.
// ----------------------------------------------------------------------------
module nsc_checker
    import nsc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       byte_stall,
    input logic [1:0] class_code,
    input logic       is_integer,
    input logic       result_valid,
    input logic       result_stall
);

    // A stalled result beat stays valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its class.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(class_code))
        else $error("result class changed while stalled");

    // The integer flag follows the class.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (is_integer == (class_code == CLS_INT)))
        else $error("integer flag disagrees with class");

    // The byte side stalls only behind a held result.
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> (result_valid && result_stall))
        else $error("byte stall without a held result");

endmodule

bind number_string_classifier nsc_checker u_nsc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_stall   (byte_stall),
    .class_code   (class_code),
    .is_integer   (is_integer),
    .result_valid (result_valid),
    .result_stall (result_stall)
);

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the number string classifier
// Sends strings one byte per beat, predicts the class of each untyped string
// from a scanner model kept in the bench, and checks each result beat in order.
// A short directed table comes first, then random literals and noise, with
// random idling on both channels and long result stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import nsc_pkg::*;

    localparam int RANDOM_ITEMS   = 1925;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 2000;

    // One row of the directed table; cls counts only when typed is set.
    typedef struct packed {
        logic [7:0] c;
        logic       eos;
        logic       typed;
        class_t     cls;
    } stim_row_t;

    // What one result beat must carry.
    typedef struct packed {
        class_t cls;
        logic   isint;
    } class_result_t;

    // Bytes that steer the scanner, used to bias the noise strings.
    localparam logic [7:0] TRICKY_CHARS [8] = '{
        CH_POINT, CH_PLUS, CH_MINUS, CH_UPPER_E, CH_LOWER_E, CH_SPACE, CH_ZERO, CH_NINE
    };

    // Directed strings: empty, whitespace only, the sign-point quirk, an
    // exponent with trailing space, a lone sign, a rejected string and a real.
    stim_row_t directed_rows [24] = '{
        '{8'h00,      1'b1, 1'b1, CLS_NOT},
        '{CH_NUL,     1'b0, 1'b1, CLS_NOT},
        '{CH_SPACE,   1'b0, 1'b0, CLS_NOT},
        '{CH_TAB,     1'b0, 1'b0, CLS_NOT},
        '{CH_NUL,     1'b0, 1'b1, CLS_NOT},
        '{CH_MINUS,   1'b0, 1'b0, CLS_NOT},
        '{CH_POINT,   1'b0, 1'b0, CLS_NOT},
        '{8'hFF,      1'b1, 1'b1, CLS_INT},
        '{CH_PLUS,    1'b0, 1'b0, CLS_NOT},
        '{8'h00,      1'b1, 1'b1, CLS_NOT},
        '{CH_CR,      1'b0, 1'b0, CLS_NOT},
        '{CH_NINE,    1'b0, 1'b0, CLS_NOT},
        '{CH_UPPER_E, 1'b0, 1'b0, CLS_NOT},
        '{CH_MINUS,   1'b0, 1'b0, CLS_NOT},
        '{CH_ZERO,    1'b0, 1'b0, CLS_NOT},
        '{CH_SPACE,   1'b0, 1'b0, CLS_NOT},
        '{8'h00,      1'b1, 1'b0, CLS_NOT},
        '{8'hFF,      1'b0, 1'b0, CLS_NOT},
        '{CH_ZERO,    1'b0, 1'b0, CLS_NOT},
        '{8'h5A,      1'b1, 1'b1, CLS_NOT},
        '{CH_ZERO,    1'b0, 1'b0, CLS_NOT},
        '{CH_POINT,   1'b0, 1'b0, CLS_NOT},
        '{8'h35,      1'b0, 1'b0, CLS_NOT},
        '{CH_NUL,     1'b0, 1'b0, CLS_NOT}
    };

    logic       clk;
    logic       rst_n;
    logic [7:0] ch;
    logic       end_of_string;
    logic       byte_valid;
    logic       byte_stall;
    logic [1:0] class_code;
    logic       is_integer;
    logic       result_valid;
    logic       result_stall;

    // Directed override that travels with the byte beat.
    logic       row_typed;
    class_t     row_cls;

    // Scanner state of the predictor.
    phase_t scan_phase    = PH_LEAD;
    logic   digit_before  = 1'b0;
    logic   digit_after   = 1'b0;
    logic   zeros_tail    = 1'b0;
    logic   rejected      = 1'b0;

    class_result_t expected_classes [$];
    logic [7:0]    literal_bytes [$];

    int mismatches     = 0;
    int send_idle_pct  = 29;
    int recv_idle_pct  = 47;
    int hold_requests  = 0;
    int holds_done     = 0;
    int stalled_cycles = 0;

    number_string_classifier u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .ch            (ch),
        .end_of_string (end_of_string),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .class_code    (class_code),
        .is_integer    (is_integer),
        .result_valid  (result_valid),
        .result_stall  (result_stall)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Advances the scanner by one byte beat. Returns 1 when the beat ends the
    // string, with the class in cls, and then clears the scanner.
    function automatic bit classify_beat(input logic [7:0] c, input logic eos,
                                         output class_t cls);
        logic sp;
        logic dg;
        logic ex;
        logic sg;
        logic pt;
        begin
            sp = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
            dg = (c >= CH_ZERO) && (c <= CH_NINE);
            ex = (c == CH_UPPER_E) || (c == CH_LOWER_E);
            sg = (c == CH_PLUS) || (c == CH_MINUS);
            pt = (c == CH_POINT);
            cls = CLS_NOT;

            if (eos || c == CH_NUL)
            begin
                if (!rejected)
                begin
                    case (scan_phase)
                        PH_INT, PH_TRAIL_INT: cls = CLS_INT;
                        PH_FRAC, PH_FRAC_SP:
                        begin
                            if (zeros_tail)
                                cls = CLS_INT;
                            else if (digit_before || digit_after)
                                cls = CLS_REAL;
                        end
                        PH_EXP_DIG, PH_TRAIL_EXP: cls = CLS_EXP;
                        default: cls = CLS_NOT;
                    endcase
                end
                scan_phase   = PH_LEAD;
                digit_before = 1'b0;
                digit_after  = 1'b0;
                zeros_tail   = 1'b0;
                rejected     = 1'b0;
                return 1'b1;
            end

            if (!rejected)
            begin
                case (scan_phase)
                    PH_LEAD, PH_SIGN:
                    begin
                        if (sp && scan_phase == PH_LEAD)
                            ;
                        else if (sg && scan_phase == PH_LEAD)
                            scan_phase = PH_SIGN;
                        else if (dg)
                        begin
                            digit_before = 1'b1;
                            scan_phase   = PH_INT;
                        end
                        else if (pt)
                        begin
                            zeros_tail = 1'b1;
                            scan_phase = PH_FRAC;
                        end
                        else
                            rejected = 1'b1;
                    end
                    PH_INT:
                    begin
                        if (dg)
                            ;
                        else if (pt)
                        begin
                            zeros_tail = 1'b1;
                            scan_phase = PH_FRAC;
                        end
                        else if (ex)
                            scan_phase = PH_EXP_MARK;
                        else if (sp)
                            scan_phase = PH_TRAIL_INT;
                        else
                            rejected = 1'b1;
                    end
                    PH_FRAC:
                    begin
                        if (dg)
                        begin
                            digit_after = 1'b1;
                            if (c != CH_ZERO)
                                zeros_tail = 1'b0;
                        end
                        else if (sp)
                            scan_phase = PH_FRAC_SP;
                        else if (ex)
                        begin
                            zeros_tail = 1'b0;
                            if (digit_before || digit_after)
                                scan_phase = PH_EXP_MARK;
                            else
                                rejected = 1'b1;
                        end
                        else
                            rejected = 1'b1;
                    end
                    PH_FRAC_SP, PH_TRAIL_INT, PH_TRAIL_EXP:
                    begin
                        if (!sp)
                            rejected = 1'b1;
                    end
                    PH_EXP_MARK:
                    begin
                        if (sg)
                            scan_phase = PH_EXP_SIGN;
                        else if (dg)
                            scan_phase = PH_EXP_DIG;
                        else
                            rejected = 1'b1;
                    end
                    PH_EXP_SIGN:
                    begin
                        if (dg)
                            scan_phase = PH_EXP_DIG;
                        else
                            rejected = 1'b1;
                    end
                    PH_EXP_DIG:
                    begin
                        if (dg)
                            ;
                        else if (sp)
                            scan_phase = PH_TRAIL_EXP;
                        else
                            rejected = 1'b1;
                    end
                    default: rejected = 1'b1;
                endcase
            end
            return 1'b0;
        end
    endfunction

    // One of the six whitespace bytes.
    function automatic logic [7:0] space_char();
        int idx;
        begin
            idx = $urandom_range(5);
            return (idx == 5) ? CH_SPACE : 8'(9 + idx);
        end
    endfunction

    function automatic logic [7:0] digit_char();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    // Fills literal_bytes with one random string, without its terminator.
    // Most strings are shaped like literals, some with one byte spoiled; the
    // rest are short noise that may hold a zero byte in the middle.
    task automatic build_string();
        begin
            literal_bytes.delete();
            if ($urandom_range(99) < 75)
            begin
                repeat ($urandom_range(2)) literal_bytes.push_back(space_char());
                if ($urandom_range(2) == 0)
                    literal_bytes.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
                repeat ($urandom_range(4)) literal_bytes.push_back(digit_char());
                if ($urandom_range(1))
                begin
                    literal_bytes.push_back(CH_POINT);
                    repeat ($urandom_range(3))
                        literal_bytes.push_back($urandom_range(2) == 0 ? digit_char() : CH_ZERO);
                end
                if ($urandom_range(3) == 0)
                begin
                    literal_bytes.push_back($urandom_range(1) ? CH_UPPER_E : CH_LOWER_E);
                    if ($urandom_range(1))
                        literal_bytes.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
                    repeat ($urandom_range(3)) literal_bytes.push_back(digit_char());
                end
                repeat ($urandom_range(2)) literal_bytes.push_back(space_char());
                if ($urandom_range(4) == 0 && literal_bytes.size() != 0)
                    literal_bytes[$urandom_range(literal_bytes.size() - 1)] =
                        8'($urandom_range(255, 1));
            end
            else
            begin
                repeat ($urandom_range(6))
                    literal_bytes.push_back($urandom_range(1) ? 8'($urandom_range(255))
                                                              : TRICKY_CHARS[$urandom_range(7)]);
            end
        end
    endtask

    // Offers one byte beat, after a random gap, and holds it until accepted.
    // Called at a falling edge and returns at a falling edge.
    task automatic send_beat(input logic [7:0] c, input logic eos,
                             input logic typed, input class_t cls);
        begin
            while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
            begin
                byte_valid <= 1'b0;
                @(negedge clk);
            end
            byte_valid    <= 1'b1;
            ch            <= c;
            end_of_string <= eos;
            row_typed     <= typed;
            row_cls       <= cls;
            do
                @(posedge clk);
            while (byte_stall !== 1'b0);
            @(negedge clk);
        end
    endtask

    // Byte side: reset, the directed table, then random strings in three
    // idling phases, then drain and report.
    initial
    begin : byte_source
        int random_items;
        class_t dont_care;
        random_items  = 0;
        dont_care     = CLS_NOT;
        rst_n         = 1'b0;
        byte_valid    = 1'b0;
        ch            = 8'h00;
        end_of_string = 1'b0;
        row_typed     = 1'b0;
        row_cls       = CLS_NOT;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].c, directed_rows[i].eos,
                      directed_rows[i].typed, directed_rows[i].cls);

        while (random_items < RANDOM_ITEMS)
        begin
            if (random_items < 650)
            begin
                send_idle_pct = 29;
                recv_idle_pct = 47;
            end
            else if (random_items < 1300)
            begin
                send_idle_pct = 47;
                recv_idle_pct = 29;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // Long result hold-offs while bytes keep coming.
            if (hold_requests == 0 && random_items >= 300)
                hold_requests = 1;
            if (hold_requests == 1 && random_items >= 1350)
                hold_requests = 2;

            build_string();
            foreach (literal_bytes[k])
                send_beat(literal_bytes[k], 1'b0, 1'b0, dont_care);
            case ($urandom_range(3))
                0: send_beat(CH_NUL, 1'b0, 1'b0, dont_care);
                1: send_beat(CH_NUL, 1'b1, 1'b0, dont_care);
                default: send_beat(8'($urandom_range(255)), 1'b1, 1'b0, dont_care);
            endcase
            random_items += literal_bytes.size() + 1;
        end
        byte_valid <= 1'b0;

        while (expected_classes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("** number_string_classifier: PASSED **");
        else
            $display("** number_string_classifier: FAILED **");
        $finish;
    end

    // Result side: random stalls, and a long hold-off whenever one is asked.
    initial
    begin : result_sink
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (holds_done < hold_requests)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                result_stall <= 1'b0;
                holds_done++;
            end
            else
                result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Sample both channels at the rising edge: predict on every accepted
    // byte beat, check every accepted result beat, and watch for a hang.
    always @(posedge clk)
    begin : beat_monitor
        logic          progress;
        class_t        cls;
        class_result_t want;
        if (rst_n)
        begin
            progress = 1'b0;
            if (byte_valid && !byte_stall)
            begin
                progress = 1'b1;
                if (classify_beat(ch, end_of_string, cls))
                begin
                    want.cls   = row_typed ? row_cls : cls;
                    want.isint = (want.cls == CLS_INT);
                    expected_classes.push_back(want);
                end
            end
            if (result_valid && !result_stall)
            begin
                progress = 1'b1;
                if (expected_classes.size() == 0)
                begin
                    $display("%0t: unexpected result beat: class %0d, is_integer %0b",
                             $time, class_code, is_integer);
                    mismatches++;
                end
                else
                begin
                    want = expected_classes.pop_front();
                    if (class_code !== want.cls || is_integer !== want.isint)
                    begin
                        $display("%0t: expected class %0d is_integer %0b, got class %0d is_integer %0b",
                                 $time, want.cls, want.isint, class_code, is_integer);
                        mismatches++;
                    end
                end
            end
            stalled_cycles = progress ? 0 : stalled_cycles + 1;
            if (stalled_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("** number_string_classifier: FAILED **");
                $finish;
            end
        end
    end

endmodule
